@@ rtl/fcp_pkg.sv @@
package fcp_pkg;

	// cordic setup
	localparam int CORDIC_ITERS = 16;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [27:0] ATAN_TAB [CORDIC_ITERS] = '{
		28'sd18432000, 28'sd10881045, 28'sd5749245, 28'sd2918407,
		28'sd1464867, 28'sd733147, 28'sd366663, 28'sd183343,
		28'sd91673, 28'sd45837, 28'sd22918, 28'sd11459,
		28'sd5730, 28'sd2865, 28'sd1432, 28'sd716
	};

	// normalizer geometry
	localparam int SQRT_STEPS = 32;
	localparam int QUOT_BITS  = 15;
	localparam int NUM_W      = 47;
	localparam int NRM_LAT    = SQRT_STEPS + QUOT_BITS + 4;

	localparam logic [15:0] ONE_Q14 = 16'd16384;

	// register map
	typedef enum logic [2:0] {
		REG_OFFSET_FWD   = 3'd0,
		REG_OFFSET_RIGHT = 3'd1,
		REG_OFFSET_UP    = 3'd2,
		REG_UP_X         = 3'd3,
		REG_UP_Y         = 3'd4,
		REG_UP_Z         = 3'd5
	} cfg_idx_t;

	// state handed from one cordic cell to the next
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [27:0] z;
		logic               neg_cos;
	} cordic_t;

	// state handed along the square root chain
	typedef struct packed {
		logic [63:0]       n;
		logic [33:0]       rem;
		logic [31:0]       root;
		logic [2:0][31:0]  mag;
		logic [2:0]        neg;
	} sqrt_t;

	// state handed along the divider chain
	typedef struct packed {
		logic [31:0]               len;
		logic [2:0][NUM_W-1:0]     rem;
		logic [2:0][QUOT_BITS-1:0] q;
		logic [2:0]                neg;
		logic                      zero;
	} div_t;

endpackage

@@ rtl/fcp_if.sv @@
interface fcp_in_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pitch_cdeg;
	logic signed [16:0] yaw_cdeg;
	logic signed [31:0] loc_x;
	logic signed [31:0] loc_y;
	logic signed [31:0] loc_z;
	logic signed [31:0] fwd_x;
	logic signed [31:0] fwd_y;
	logic signed [31:0] fwd_z;
	modport source (output valid, pitch_cdeg, yaw_cdeg, loc_x, loc_y, loc_z,
		fwd_x, fwd_y, fwd_z, input ready);
	modport sink (input valid, pitch_cdeg, yaw_cdeg, loc_x, loc_y, loc_z,
		fwd_x, fwd_y, fwd_z, output ready);
endinterface

interface fcp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cam_x;
	logic signed [31:0] cam_y;
	logic signed [31:0] cam_z;
	logic signed [15:0] look_x;
	logic signed [15:0] look_y;
	logic signed [15:0] look_z;
	modport source (output valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
		input ready);
	modport sink (input valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
		output ready);
endinterface

interface fcp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/fcp_dly.sv @@
module fcp_dly #(
	parameter int W = 32,
	parameter int D = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [D];

	// shift line advancing with the pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[D-1];

endmodule

@@ rtl/fcp_cordic_cell.sv @@
module fcp_cordic_cell import fcp_pkg::*; #(
	parameter int I = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d_in,
	output cordic_t d_out
);

	logic signed [31:0] dx, dy;
	cordic_t nxt;

	// one rotation step, direction from the residual angle sign
	always_comb begin
		dx = $signed(d_in.y) >>> I;
		dy = $signed(d_in.x) >>> I;
		nxt = d_in;
		if (!d_in.z[27]) begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - ATAN_TAB[I];
		end else begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + ATAN_TAB[I];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ rtl/fcp_sqrt_cell.sv @@
module fcp_sqrt_cell import fcp_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t d_in,
	output sqrt_t d_out
);

	logic [35:0] t;
	logic [35:0] trial;
	logic        ge;
	sqrt_t       nxt;

	// one root bit per cell from the next two radicand bits
	always_comb begin
		t = {d_in.rem, d_in.n[63:62]};
		trial = {2'b00, d_in.root, 2'b01};
		ge = (t >= trial);
		nxt = d_in;
		nxt.n = {d_in.n[61:0], 2'b00};
		nxt.rem = ge ? 34'(t - trial) : t[33:0];
		nxt.root = {d_in.root[30:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ rtl/fcp_div_cell.sv @@
module fcp_div_cell import fcp_pkg::*; #(
	parameter int B = 0
) (
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	logic [NUM_W-1:0] dsh;
	div_t nxt;

	// one quotient bit for each of the three components
	always_comb begin
		dsh = NUM_W'(d_in.len) << B;
		nxt = d_in;
		for (int k = 0; k < 3; k++) begin
			if (d_in.rem[k] >= dsh) begin
				nxt.rem[k] = d_in.rem[k] - dsh;
				nxt.q[k][B] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

@@ rtl/fcp_nrm.sv @@
module fcp_nrm import fcp_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [2:0][32:0] v,
	output logic [2:0][15:0] o
);

	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [2:0][63:0] sq_s1;
	sqrt_t            sq_ch [SQRT_STEPS+1];
	div_t             dv_ch [QUOT_BITS+1];
	div_t             prep;
	logic [2:0][15:0] o_nxt;
	logic [QUOT_BITS-1:0] qc;

	// magnitudes and squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= v[k][32];
				mag_s1[k] <= v[k][32] ? 32'(-v[k]) : v[k][31:0];
				sq_s1[k] <= 64'(v[k][32] ? 32'(-v[k]) : v[k][31:0])
					* 64'(v[k][32] ? 32'(-v[k]) : v[k][31:0]);
			end
		end
	end

	// sum of squares enters the root chain
	always_ff @(posedge clk) begin
		if (en) begin
			sq_ch[0].n <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			sq_ch[0].rem <= '0;
			sq_ch[0].root <= '0;
			sq_ch[0].mag <= mag_s1;
			sq_ch[0].neg <= neg_s1;
		end
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		fcp_sqrt_cell u_cell (.clk(clk), .en(en), .d_in(sq_ch[i]), .d_out(sq_ch[i+1]));
	end

	// rounded numerators
	always_comb begin
		prep.len = sq_ch[SQRT_STEPS].root;
		prep.q = '0;
		prep.neg = sq_ch[SQRT_STEPS].neg;
		prep.zero = (sq_ch[SQRT_STEPS].root == '0);
		for (int k = 0; k < 3; k++) begin
			prep.rem[k] = {1'b0, sq_ch[SQRT_STEPS].mag[k], 14'b0}
				+ NUM_W'(sq_ch[SQRT_STEPS].root >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ch[0] <= prep;
		end
	end

	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
		fcp_div_cell #(.B(QUOT_BITS-1-j)) u_cell (
			.clk(clk), .en(en), .d_in(dv_ch[j]), .d_out(dv_ch[j+1]));
	end

	// clamp, sign and zero-length vector
	always_comb begin
		qc = '0;
		for (int k = 0; k < 3; k++) begin
			qc = (dv_ch[QUOT_BITS].q[k] > QUOT_BITS'(ONE_Q14))
				? QUOT_BITS'(ONE_Q14) : dv_ch[QUOT_BITS].q[k];
			if (dv_ch[QUOT_BITS].zero) begin
				o_nxt[k] = '0;
			end else if (dv_ch[QUOT_BITS].neg[k]) begin
				o_nxt[k] = 16'(-{1'b0, qc});
			end else begin
				o_nxt[k] = {1'b0, qc};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o <= o_nxt;
		end
	end

endmodule

@@ rtl/follow_camera_pose.sv @@
// follow camera pose
// pose_in carries one request per target: pitch and yaw in hundredths of a
// degree, location and unnormalized forward vector. pose_out returns the
// camera position (Q16.16, saturated) and the look direction (Q2.14).
// cfg writes the socket offsets and the up vector by register index; it is
// always ready and should be written only while no request is in flight.
// One request is accepted every cycle while pose_out is not stalled: the
// work runs down a chain of cells (16 cordic rotation cells per angle,
// 32 square root cells and 15 divider cells per vector) that all advance
// together, one step per cell per cycle.
// When pose_out stalls the whole chain holds, pose_in.ready drops, and the
// result stays stable on the output register until taken.
// Reset clears the pipeline valids and loads the default offsets
// (forward -2.0) and up vector (0, 0, 1).
module follow_camera_pose import fcp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	fcp_in_if.sink           pose_in,
	fcp_out_if.source        pose_out,
	fcp_cfg_if.sink          cfg
);

	localparam int ST_LOOK = CORDIC_ITERS + 3;
	localparam int ST_CR   = ST_LOOK + 2;
	localparam int ST_NRM  = ST_CR + NRM_LAT;
	localparam int ST_OUT  = ST_NRM + 2;

	logic               adv;
	logic [ST_OUT-1:0]  vld_q;
	logic signed [31:0] off_fwd_q, off_right_q, off_up_q;
	logic signed [15:0] up_q [3];

	cordic_t pch [CORDIC_ITERS+1];
	cordic_t yaw [CORDIC_ITERS+1];

	logic signed [15:0] sp_s18, cp_s18, sy_s18, cy_s18;
	logic signed [15:0] look_s19 [3];
	logic signed [31:0] xp_s20 [6];
	logic [2:0][32:0]   cr_s21;
	logic [95:0]        fwd_d;
	logic [2:0][32:0]   fwd_v;
	logic [2:0][15:0]   nf, nr;
	logic [95:0]        loc_d;
	logic [47:0]        look_d;
	logic signed [47:0] pf_s73 [3], pr_s73 [3], pu_s73 [3];
	logic signed [31:0] cam_s74 [3];
	logic signed [31:0] cam_nxt [3];

	// angle reduction into the cordic range
	function automatic cordic_t reduce(input logic signed [16:0] a);
		logic [17:0]        s;
		logic signed [17:0] r;
		cordic_t            c;
		s = 18'(int'(a) + 72000);
		if (s >= 18'd108000) begin
			s = s - 18'd108000;
		end else if (s >= 18'd72000) begin
			s = s - 18'd72000;
		end else if (s >= 18'd36000) begin
			s = s - 18'd36000;
		end
		r = $signed(s);
		if (r >= 18'sd18000) begin
			r = r - 18'sd36000;
		end
		c.neg_cos = 1'b0;
		if (r > 18'sd9000) begin
			r = 18'sd18000 - r;
			c.neg_cos = 1'b1;
		end else if (r < -18'sd9000) begin
			r = -18'sd18000 - r;
			c.neg_cos = 1'b1;
		end
		c.x = CORDIC_GAIN;
		c.y = '0;
		c.z = $signed({r[15:0], 12'b0});
		return c;
	endfunction

	// Q2.30 to Q2.14 with rounding and clamp
	function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
		logic signed [32:0] t;
		logic signed [16:0] h;
		t = 33'(v) + 33'sd32768;
		h = 17'(t >>> 16);
		if (h > 17'sd16384) begin
			h = 17'sd16384;
		end else if (h < -17'sd16384) begin
			h = -17'sd16384;
		end
		return h[15:0];
	endfunction

	// Q4.28 product back to Q2.14
	function automatic logic signed [15:0] rnd14(input logic signed [31:0] p);
		logic signed [32:0] t;
		t = (33'(p) + 33'sd8192) >>> 14;
		return t[15:0];
	endfunction

	// global advance: the chain moves unless the result is held
	assign adv = !vld_q[ST_OUT-1] || pose_out.ready;
	assign pose_in.ready = adv;
	assign pose_out.valid = vld_q[ST_OUT-1];
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[ST_OUT-2:0], pose_in.valid};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_fwd_q <= -32'sd131072;
			off_right_q <= '0;
			off_up_q <= '0;
			up_q[0] <= '0;
			up_q[1] <= '0;
			up_q[2] <= 16'sd16384;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_OFFSET_FWD:   off_fwd_q <= cfg.data;
				REG_OFFSET_RIGHT: off_right_q <= cfg.data;
				REG_OFFSET_UP:    off_up_q <= cfg.data;
				REG_UP_X:         up_q[0] <= cfg.data[15:0];
				REG_UP_Y:         up_q[1] <= cfg.data[15:0];
				REG_UP_Z:         up_q[2] <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// reduced angles seed the cordic chains
	always_ff @(posedge clk) begin
		if (adv) begin
			pch[0] <= reduce(pose_in.pitch_cdeg);
			yaw[0] <= reduce(pose_in.yaw_cdeg);
		end
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
		fcp_cordic_cell #(.I(i)) u_pch (
			.clk(clk), .en(adv), .d_in(pch[i]), .d_out(pch[i+1]));
		fcp_cordic_cell #(.I(i)) u_yaw (
			.clk(clk), .en(adv), .d_in(yaw[i]), .d_out(yaw[i+1]));
	end

	// sine and cosine in Q2.14
	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s18 <= to_q14(pch[CORDIC_ITERS].y);
			cp_s18 <= pch[CORDIC_ITERS].neg_cos ? -to_q14(pch[CORDIC_ITERS].x)
				: to_q14(pch[CORDIC_ITERS].x);
			sy_s18 <= to_q14(yaw[CORDIC_ITERS].y);
			cy_s18 <= yaw[CORDIC_ITERS].neg_cos ? -to_q14(yaw[CORDIC_ITERS].x)
				: to_q14(yaw[CORDIC_ITERS].x);
		end
	end

	// look direction
	always_ff @(posedge clk) begin
		if (adv) begin
			look_s19[0] <= rnd14(32'(cp_s18 * cy_s18));
			look_s19[1] <= rnd14(32'(cp_s18 * sy_s18));
			look_s19[2] <= sp_s18;
		end
	end

	// cross product of look and up
	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s20[0] <= 32'(look_s19[1] * up_q[2]);
			xp_s20[1] <= 32'(look_s19[2] * up_q[1]);
			xp_s20[2] <= 32'(look_s19[2] * up_q[0]);
			xp_s20[3] <= 32'(look_s19[0] * up_q[2]);
			xp_s20[4] <= 32'(look_s19[0] * up_q[1]);
			xp_s20[5] <= 32'(look_s19[1] * up_q[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s21[0] <= 33'(33'(xp_s20[0]) - 33'(xp_s20[1]));
			cr_s21[1] <= 33'(33'(xp_s20[2]) - 33'(xp_s20[3]));
			cr_s21[2] <= 33'(33'(xp_s20[4]) - 33'(xp_s20[5]));
		end
	end

	// forward vector waits for the cross product
	fcp_dly #(.W(96), .D(ST_CR)) u_fwd_dly (
		.clk(clk), .en(adv),
		.d({pose_in.fwd_z, pose_in.fwd_y, pose_in.fwd_x}), .q(fwd_d));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fwd_v[k] = {fwd_d[32*k+31], fwd_d[32*k +: 32]};
		end
	end

	fcp_nrm u_nrm_fwd (.clk(clk), .en(adv), .v(fwd_v), .o(nf));
	fcp_nrm u_nrm_right (.clk(clk), .en(adv), .v(cr_s21), .o(nr));

	fcp_dly #(.W(96), .D(ST_NRM+1)) u_loc_dly (
		.clk(clk), .en(adv),
		.d({pose_in.loc_z, pose_in.loc_y, pose_in.loc_x}), .q(loc_d));

	fcp_dly #(.W(48), .D(ST_OUT-ST_LOOK)) u_look_dly (
		.clk(clk), .en(adv),
		.d({look_s19[2], look_s19[1], look_s19[0]}), .q(look_d));

	// offset products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pf_s73[k] <= $signed(nf[k]) * off_fwd_q;
				pr_s73[k] <= (-$signed(17'($signed(nr[k])))) * off_right_q;
				pu_s73[k] <= up_q[k] * off_up_q;
			end
		end
	end

	// sum at Q20.30, round and saturate
	always_comb begin
		logic signed [49:0] acc;
		logic signed [35:0] rs;
		for (int k = 0; k < 3; k++) begin
			acc = $signed({{4{loc_d[32*k+31]}}, loc_d[32*k +: 32], 14'b0})
				+ 50'(pf_s73[k]) + 50'(pr_s73[k]) + 50'(pu_s73[k]);
			rs = 36'((acc + 50'sd8192) >>> 14);
			if (rs > 36'sd2147483647) begin
				cam_nxt[k] = 32'sh7fffffff;
			end else if (rs < -36'sd2147483648) begin
				cam_nxt[k] = 32'sh80000000;
			end else begin
				cam_nxt[k] = rs[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cam_s74 <= cam_nxt;
		end
	end

	assign pose_out.cam_x = cam_s74[0];
	assign pose_out.cam_y = cam_s74[1];
	assign pose_out.cam_z = cam_s74[2];
	assign pose_out.look_x = look_d[15:0];
	assign pose_out.look_y = look_d[31:16];
	assign pose_out.look_z = look_d[47:32];

endmodule
